// ===== rtl/mme_pkg.sv =====
// Shared types and constants of the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

    // Widths fixed by the item and register formats
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int EFF_W  = DIM_W + 1;
    localparam int REQ_W  = 2;
    localparam int CFG_W  = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    // Register indexes
    localparam logic [CFG_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef logic [DATA_W-1:0] t_word;

endpackage

// ===== rtl/mme_req_if.sv =====
// Request channel: element loads and compute commands.
`timescale 1ns / 1ps

interface mme_req_if;
    logic                             valid;
    logic                             ready;
    logic [mme_pkg::REQ_W-1:0]        req_type;
    logic [mme_pkg::IDX_W-1:0]        row_index;
    logic [mme_pkg::IDX_W-1:0]        col_index;
    logic signed [mme_pkg::DATA_W-1:0] element_value;

    modport source (output valid, req_type, row_index, col_index, element_value,
                    input ready);
    modport sink   (input valid, req_type, row_index, col_index, element_value,
                    output ready);
endinterface

// ===== rtl/mme_res_if.sv =====
// Result channel: one product element per item.
`timescale 1ns / 1ps

interface mme_res_if;
    logic                              valid;
    logic                              ready;
    logic [mme_pkg::IDX_W-1:0]         out_row;
    logic [mme_pkg::IDX_W-1:0]         out_col;
    logic signed [mme_pkg::DATA_W-1:0] product_value;
    logic                              saturated;
    logic                              last;

    modport source (output valid, out_row, out_col, product_value, saturated, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, product_value, saturated, last,
                    output ready);
endinterface

// ===== rtl/mme_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps

interface mme_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [mme_pkg::CFG_W-1:0] reg_index;
    logic [mme_pkg::DIM_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/mme_store.sv =====
// Matrix element store: one write port, registered read, per-entry valid bits.
`timescale 1ns / 1ps

module mme_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  mme_pkg::t_word      i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output mme_pkg::t_word      o_rd_data
);

    mme_pkg::t_word r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    mme_pkg::t_word   r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// Top level of the matrix multiply engine: sequencer, multiply-accumulate unit, output register.
`timescale 1ns / 1ps

// Dense C = A x B on signed fixed-point elements with FRAC_BITS fractional bits.
// A load item (write A or write B) stores one element and gives no
// result; a write outside the configured size is dropped. Both stores read as zero
// after reset until written. A compute item emits rows_a x cols_b results in
// row-major order, each the exact dot product rounded toward minus infinity and
// saturated to 32 bits with a flag, with last marking the final element. Dimension
// registers above MAX_DIM act as MAX_DIM; a zero rows_a or cols_b gives no result.
// A compute holds the request channel until its final result enters the output
// register. One multiply-accumulate unit fed by one read port per store handles
// one term a cycle while an element's terms are issued; then the terms drain
// through read, multiply and accumulate, and the element is finalized. The next
// element is computed while a result waits in the output register, and loads are
// taken while the final result waits.
module matrix_multiply_engine #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mme_req_if.sink   i_req,
    mme_cfg_if.sink   i_cfg,
    mme_res_if.source o_res
);

    localparam int DATA_W = mme_pkg::DATA_W;
    localparam int EFF_W  = mme_pkg::EFF_W;
    localparam int IDX_W  = mme_pkg::IDX_W;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + mme_pkg::DIM_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // Configuration
    logic [mme_pkg::DIM_W-1:0] r_rows_a, r_inner_dim, r_cols_b;
    logic [EFF_W-1:0]          eff_r, eff_k, eff_c;

    function automatic logic [EFF_W-1:0] clamp_dim(input logic [mme_pkg::DIM_W-1:0] d);
        logic [EFF_W-1:0] dx;
        dx = {1'b0, d};
        return (dx > EFF_W'(MAX_DIM)) ? EFF_W'(MAX_DIM) : dx;
    endfunction

    assign eff_r = clamp_dim(r_rows_a);
    assign eff_k = clamp_dim(r_inner_dim);
    assign eff_c = clamp_dim(r_cols_b);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mme_pkg::DIM_RESET;
            r_inner_dim <= mme_pkg::DIM_RESET;
            r_cols_b    <= mme_pkg::DIM_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                mme_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg.wr_data;
                mme_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg.wr_data;
                mme_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg.wr_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_row, n_row, r_col, n_col, r_k, n_k;
    logic                    r_s1_vld, r_s2_vld, issue;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;

    logic                    r_out_valid, n_out_valid;
    logic [IDX_W-1:0]        r_out_row, n_out_row, r_out_col, n_out_col;
    logic [DATA_W-1:0]       r_out_val, n_out_val;
    logic                    r_out_sat, n_out_sat, r_out_last, n_out_last;

    logic req_fire;
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // Load path: bounds check against the configured size
    logic [EFF_W-1:0] wr_row, wr_col;
    logic [AW-1:0]    wr_addr;
    logic             wr_a, wr_b;

    assign wr_row  = EFF_W'(i_req.row_index);
    assign wr_col  = EFF_W'(i_req.col_index);
    assign wr_addr = AW'(int'(i_req.row_index) * MAX_DIM + int'(i_req.col_index));
    assign wr_a    = req_fire && (i_req.req_type == mme_pkg::REQ_WRITE_A)
                     && (wr_row < eff_r) && (wr_col < eff_k);
    assign wr_b    = req_fire && (i_req.req_type == mme_pkg::REQ_WRITE_B)
                     && (wr_row < eff_k) && (wr_col < eff_c);

    // Operand reads: A[row][k] and B[k][col]
    logic [AW-1:0]  rd_addr_a, rd_addr_b;
    mme_pkg::t_word rd_a, rd_b;

    assign rd_addr_a = AW'(int'(r_row) * MAX_DIM + int'(r_k));
    assign rd_addr_b = AW'(int'(r_k) * MAX_DIM + int'(r_col));

    mme_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_a),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_req.element_value),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (rd_a)
    );

    mme_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_req.element_value),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (rd_b)
    );

    // Shared multiplier, one term per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(rd_a) * $signed(rd_b);
    end

    // Finalize: floor shift, then clip to 32 bits
    logic signed [ACC_W-1:0]   acc_shift;
    logic [ACC_W-DATA_W:0]     acc_hi;
    logic                      fits;
    logic [DATA_W-1:0]         fin_val;

    assign acc_shift = r_acc >>> FRAC_BITS;
    assign acc_hi    = acc_shift[ACC_W-1:DATA_W-1];
    assign fits      = (&acc_hi) || !(|acc_hi);
    assign fin_val   = fits ? acc_shift[DATA_W-1:0]
                     : (r_acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}});

    logic col_end, row_end, out_free;
    assign col_end  = (EFF_W'(r_col) + 1'b1) == eff_c;
    assign row_end  = (EFF_W'(r_row) + 1'b1) == eff_r;
    assign out_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_val   = r_out_val;
        n_out_sat   = r_out_sat;
        n_out_last  = r_out_last;
        issue       = 1'b0;

        // Accumulate products as they leave the multiplier
        if (r_s2_vld) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_fire && (i_req.req_type == mme_pkg::REQ_COMPUTE)
                    && (eff_r != '0) && (eff_c != '0)) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (eff_k == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    issue = 1'b1;
                    if ((EFF_W'(r_k) + 1'b1) == eff_k) begin
                        n_k     = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                // Wait for the last term to reach the accumulator
                if (!r_s1_vld && !r_s2_vld) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = IDX_W'(r_row);
                    n_out_col   = IDX_W'(r_col);
                    n_out_val   = fin_val;
                    n_out_sat   = !fits;
                    n_out_last  = col_end && row_end;
                    n_acc       = '0;
                    if (col_end) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                    n_state = (col_end && row_end) ? ST_IDLE : ST_MAC;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s1_vld    <= issue;
            r_s2_vld    <= r_s1_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_k        <= n_k;
        r_acc      <= n_acc;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_val  <= n_out_val;
        r_out_sat  <= n_out_sat;
        r_out_last <= n_out_last;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.out_row       = r_out_row;
    assign o_res.out_col       = r_out_col;
    assign o_res.product_value = r_out_val;
    assign o_res.saturated     = r_out_sat;
    assign o_res.last          = r_out_last;

endmodule

// ===== tb/sv/matrix_multiply_engine_test.sv =====
// Self-checking test of the matrix multiply engine: directed table, then random load/compute phases.
`timescale 1ns / 1ps

module matrix_multiply_engine_test;

    localparam int MAX_DIM       = 8;
    localparam int FRAC_BITS     = 16;
    localparam int REQ_W         = mme_pkg::REQ_W;
    localparam int IDX_W         = mme_pkg::IDX_W;
    localparam int DIM_W         = mme_pkg::DIM_W;
    localparam int CFG_W         = mme_pkg::CFG_W;
    localparam int TOTAL_ITEMS   = 380;
    // Covers the longest compute with margin.
    localparam int SETTLE_CYCLES = 800;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam int WATCHDOG_NS   = 20_000_000;

    // Codes the block must ignore.
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam logic [CFG_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {STEP_REQ, STEP_CFG} t_step_kind;

    // One row of the directed table. For a register write, code is the index
    // and the low bits of value are the data. A compute row with typed set
    // carries the value and flag every product element must show.
    typedef struct packed {
        t_step_kind        kind;
        logic [REQ_W-1:0]  code;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        mme_pkg::t_word    value;
        logic              typed;
        mme_pkg::t_word    want;
        logic              want_sat;
    } t_step;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        mme_pkg::t_word   value;
        logic             sat;
        logic             last;
    } t_product;

    localparam int DIRECTED_COUNT = 33;

    t_step directed_steps [DIRECTED_COUNT] = '{
        // Right after reset: 8 x 8 x 8 over cleared stores gives 64 zeros.
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
        '{STEP_CFG, mme_pkg::CFG_ROWS_A,    3'd0, 3'd0, 32'd1, 1'b0, 32'h0, 1'b0},
        '{STEP_CFG, mme_pkg::CFG_INNER_DIM, 3'd0, 3'd0, 32'd1, 1'b0, 32'h0, 1'b0},
        '{STEP_CFG, mme_pkg::CFG_COLS_B,    3'd0, 3'd0, 32'd1, 1'b0, 32'h0, 1'b0},
        // Largest positive squared clips high.
        '{STEP_REQ, mme_pkg::REQ_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_WRITE_B, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
        // Mixed signs clip low.
        '{STEP_REQ, mme_pkg::REQ_WRITE_B, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'h8000_0000, 1'b1},
        // Most negative squared clips high.
        '{STEP_REQ, mme_pkg::REQ_WRITE_A, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
        // Tiny negative product rounds down to minus one ulp, not to zero.
        '{STEP_REQ, mme_pkg::REQ_WRITE_A, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_WRITE_B, 3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0},
        // Out-of-range writes and the unused request code leave the stores alone.
        '{STEP_REQ, mme_pkg::REQ_WRITE_A, 3'd1, 3'd0, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_WRITE_B, 3'd0, 3'd7, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_WRITE_A, 3'd7, 3'd7, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, REQ_SPARE,            3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0},
        // Zero inner dimension: every write is dropped, every element is zero.
        '{STEP_CFG, mme_pkg::CFG_INNER_DIM, 3'd0, 3'd0, 32'd0, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_WRITE_A, 3'd0, 3'd0, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0000_0000, 1'b0},
        // Zero rows, then zero columns: compute gives nothing.
        '{STEP_CFG, mme_pkg::CFG_ROWS_A,    3'd0, 3'd0, 32'd0, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{STEP_CFG, mme_pkg::CFG_ROWS_A,    3'd0, 3'd0, 32'd15, 1'b0, 32'h0, 1'b0},
        '{STEP_CFG, mme_pkg::CFG_INNER_DIM, 3'd0, 3'd0, 32'd15, 1'b0, 32'h0, 1'b0},
        '{STEP_CFG, mme_pkg::CFG_COLS_B,    3'd0, 3'd0, 32'd0, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        // Sizes above the maximum act as the maximum; the spare index is ignored.
        '{STEP_CFG, mme_pkg::CFG_COLS_B,    3'd0, 3'd0, 32'd9, 1'b0, 32'h0, 1'b0},
        '{STEP_CFG, CFG_SPARE,              3'd0, 3'd0, 32'd6, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_WRITE_A, 3'd7, 3'd7, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_WRITE_B, 3'd7, 3'd7, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{STEP_REQ, mme_pkg::REQ_COMPUTE, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    mme_req_if req_ch ();
    mme_cfg_if cfg_ch ();
    mme_res_if res_ch ();

    matrix_multiply_engine #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // Shadow copy of the stores and size registers.
    mme_pkg::t_word   a_shadow [MAX_DIM*MAX_DIM];
    mme_pkg::t_word   b_shadow [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0] dim_rows;
    logic [DIM_W-1:0] dim_inner;
    logic [DIM_W-1:0] dim_cols;

    t_product pending_products [$];
    int       mismatches;
    int       sent_items;
    bit       hold_off_req;   // ask the result side for one long stall
    bit       unsettled;      // a request went in since the last settle
    bit       steady_sender;  // no gaps on the request side this phase

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("matrix_multiply_engine test failed");
        $finish;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    // Mostly zero, sometimes a few cycles, now and then a long pause.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 0;
        if (pick < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, what);
    endfunction

    // Apply one accepted request to the shadow state and queue the product
    // elements it yields.
    function automatic void apply_request(input logic [REQ_W-1:0] code,
                                          input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input mme_pkg::t_word value,
                                          input bit typed,
                                          input mme_pkg::t_word want,
                                          input logic want_sat);
        int                  nr;
        int                  nk;
        int                  nc;
        logic signed [63:0]  term;
        logic signed [127:0] acc;
        logic signed [127:0] scaled;
        t_product            p;
        nr = eff_dim(dim_rows);
        nk = eff_dim(dim_inner);
        nc = eff_dim(dim_cols);
        case (code)
            mme_pkg::REQ_WRITE_A: begin
                if (int'(row) < nr && int'(col) < nk)
                    a_shadow[int'(row)*MAX_DIM + int'(col)] = value;
            end
            mme_pkg::REQ_WRITE_B: begin
                if (int'(row) < nk && int'(col) < nc)
                    b_shadow[int'(row)*MAX_DIM + int'(col)] = value;
            end
            mme_pkg::REQ_COMPUTE: begin
                for (int r = 0; r < nr; r++) begin
                    for (int c = 0; c < nc; c++) begin
                        acc = '0;
                        for (int k = 0; k < nk; k++) begin
                            term = $signed(a_shadow[r*MAX_DIM + k]) *
                                   $signed(b_shadow[k*MAX_DIM + c]);
                            acc = acc + term;
                        end
                        // Arithmetic shift floors toward minus infinity.
                        scaled = acc >>> FRAC_BITS;
                        p.row = IDX_W'(r);
                        p.col = IDX_W'(c);
                        p.last = (r == nr - 1) && (c == nc - 1);
                        if (typed) begin
                            p.value = want;
                            p.sat = want_sat;
                        end else if (&scaled[127:31] || ~|scaled[127:31]) begin
                            p.value = scaled[31:0];
                            p.sat = 1'b0;
                        end else begin
                            p.value = scaled[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            p.sat = 1'b1;
                        end
                        pending_products.push_back(p);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one item, hold it until taken, then predict. Valid stays high on
    // return so that back-to-back items need no extra assignment.
    task automatic send_request(input logic [REQ_W-1:0] code,
                                input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col,
                                input mme_pkg::t_word value,
                                input bit typed = 1'b0,
                                input mme_pkg::t_word want = '0,
                                input logic want_sat = 1'b0);
        int gap;
        gap = steady_sender ? 0 : gap_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= code;
        req_ch.row_index     <= row;
        req_ch.col_index     <= col;
        req_ch.element_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        unsettled = 1'b1;
        sent_items++;
        apply_request(code, row, col, value, typed, want, want_sat);
    endtask

    // Drop valid and hold until every queued product element has arrived.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_products.size() != 0);
    endtask

    // Write a size register with the block idle: drain, let any compute that
    // gives no result run out, then hand the write over.
    task automatic write_register(input logic [CFG_W-1:0] idx,
                                  input logic [DIM_W-1:0] data);
        wait_for_drain();
        if (unsettled) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            unsettled = 1'b0;
        end
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            mme_pkg::CFG_ROWS_A:    dim_rows  = data;
            mme_pkg::CFG_INNER_DIM: dim_inner = data;
            mme_pkg::CFG_COLS_B:    dim_cols  = data;
            default: ;
        endcase
    endtask

    // Mostly small sizes, some up to the maximum, a few zero or above it.
    function automatic logic [DIM_W-1:0] pick_dim();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13) return DIM_W'($urandom_range(1, 4));
        if (pick < 16) return DIM_W'($urandom_range(5, 8));
        if (pick < 17) return '0;
        return DIM_W'($urandom_range(9, 15));
    endfunction

    // Q16.16 values: mostly within +-4.0, some full range, some extremes.
    function automatic mme_pkg::t_word pick_element();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 4))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h0001_0000;
                default: return 32'h0000_0000;
            endcase
        end
        if (pick < 4) return $urandom;
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    // A write that the block has to drop: an index past the size, or the
    // unused request code.
    task automatic send_noise(input logic [REQ_W-1:0] code, input int nrow, input int ncol);
        logic [REQ_W-1:0] kind;
        int               row;
        int               col;
        kind = code;
        row = $urandom_range(0, MAX_DIM - 1);
        col = $urandom_range(0, MAX_DIM - 1);
        if (nrow < MAX_DIM && $urandom_range(0, 1) == 1)
            row = $urandom_range(nrow, MAX_DIM - 1);
        else if (ncol < MAX_DIM)
            col = $urandom_range(ncol, MAX_DIM - 1);
        else
            kind = REQ_SPARE;
        if ($urandom_range(0, 3) == 0)
            kind = REQ_SPARE;
        send_request(kind, IDX_W'(row), IDX_W'(col), $urandom);
    endtask

    // Walk one matrix in row-major order, writing each element with the given
    // percent chance and sprinkling in dropped writes.
    task automatic fill_matrix(input logic [REQ_W-1:0] code, input int nrow, input int ncol,
                               input int density);
        for (int i = 0; i < nrow; i++) begin
            for (int j = 0; j < ncol; j++) begin
                if ($urandom_range(1, 100) <= density)
                    send_request(code, IDX_W'(i), IDX_W'(j), pick_element());
                if ($urandom_range(0, 9) == 0)
                    send_noise(code, nrow, ncol);
            end
        end
    endtask

    // One random phase: new sizes, then one or two rounds of fill and compute.
    // The stall phase runs at full size and asks the result side for a long
    // hold-off right after its first compute, while the second round of loads
    // keeps pushing on the request side.
    task automatic run_phase(input bit stall_phase);
        int nr;
        int nk;
        int nc;
        int rounds;
        write_register(mme_pkg::CFG_ROWS_A,
                       stall_phase ? mme_pkg::DIM_RESET : pick_dim());
        write_register(mme_pkg::CFG_INNER_DIM,
                       stall_phase ? mme_pkg::DIM_RESET : pick_dim());
        write_register(mme_pkg::CFG_COLS_B,
                       stall_phase ? mme_pkg::DIM_RESET : pick_dim());
        if ($urandom_range(0, 4) == 0)
            write_register(CFG_SPARE, DIM_W'($urandom));
        nr = eff_dim(dim_rows);
        nk = eff_dim(dim_inner);
        nc = eff_dim(dim_cols);
        steady_sender = ($urandom_range(0, 3) == 0);
        rounds = stall_phase ? 2 : $urandom_range(1, 2);
        for (int n = 0; n < rounds; n++) begin
            fill_matrix(mme_pkg::REQ_WRITE_A, nr, nk, (n == 0) ? 85 : 30);
            fill_matrix(mme_pkg::REQ_WRITE_B, nk, nc, (n == 0) ? 85 : 30);
            send_request(mme_pkg::REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            if (stall_phase && n == 0)
                hold_off_req = 1'b1;
            else if ($urandom_range(0, 3) == 0)
                wait_for_drain();
        end
    endtask

    // Result side: ready in bursts with random gaps, and one long hold-off on
    // request, counted here.
    initial begin : result_acceptor
        int burst;
        int gap;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            burst = $urandom_range(1, 30);
            res_ch.ready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = gap_len();
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Compare each accepted product element against the oldest prediction.
    always @(posedge i_clk) begin : product_checker
        t_product want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_products.size() == 0) begin
                report_mismatch($sformatf("unexpected element (%0d,%0d) value %h sat %b last %b",
                                          res_ch.out_row, res_ch.out_col, res_ch.product_value,
                                          res_ch.saturated, res_ch.last));
            end else begin
                want = pending_products.pop_front();
                if (res_ch.out_row !== want.row || res_ch.out_col !== want.col ||
                    res_ch.product_value !== want.value || res_ch.saturated !== want.sat ||
                    res_ch.last !== want.last) begin
                    report_mismatch($sformatf(
                        "expected (%0d,%0d) %h sat %b last %b, got (%0d,%0d) %h sat %b last %b",
                        want.row, want.col, want.value, want.sat, want.last,
                        res_ch.out_row, res_ch.out_col, res_ch.product_value,
                        res_ch.saturated, res_ch.last));
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = mme_pkg::REQ_WRITE_A;
        req_ch.row_index     = '0;
        req_ch.col_index     = '0;
        req_ch.element_value = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.reg_index     = mme_pkg::CFG_ROWS_A;
        cfg_ch.wr_data       = '0;
        mismatches           = 0;
        sent_items           = 0;
        hold_off_req         = 1'b0;
        unsettled            = 1'b0;
        steady_sender        = 1'b0;
        // Reset state: both stores cleared, every size at its reset value.
        for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
            a_shadow[i] = '0;
            b_shadow[i] = '0;
        end
        dim_rows  = mme_pkg::DIM_RESET;
        dim_inner = mme_pkg::DIM_RESET;
        dim_cols  = mme_pkg::DIM_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            if (directed_steps[i].kind == STEP_CFG)
                write_register(directed_steps[i].code, directed_steps[i].value[DIM_W-1:0]);
            else
                send_request(directed_steps[i].code, directed_steps[i].row,
                             directed_steps[i].col, directed_steps[i].value,
                             directed_steps[i].typed, directed_steps[i].want,
                             directed_steps[i].want_sat);
        end

        // Random phases until enough items have gone in, stall phase included.
        phase = 0;
        while (sent_items < TOTAL_ITEMS || phase <= 2) begin
            run_phase(phase == 2);
            phase++;
        end

        // Drain, then watch a while longer for stray elements.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("matrix_multiply_engine test passed");
        else
            $display("matrix_multiply_engine test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mme_pkg.sv
rtl/mme_req_if.sv
rtl/mme_res_if.sv
rtl/mme_cfg_if.sv
rtl/mme_store.sv
rtl/matrix_multiply_engine.sv
tb/sv/matrix_multiply_engine_test.sv
